// ----- hdl/pil_pkg.sv -----
// Package with the shared constants, codes and control structs of the pack index lookup unit.
`default_nettype none
package pil_pkg;

   localparam int MAX_OBJECTS   = 4096;
   localparam int OBJ_AW        = $clog2(MAX_OBJECTS);
   localparam int CNT_W         = OBJ_AW + 1;
   localparam int FAN_ENTRIES   = 256;
   localparam int FAN_AW        = 8;
   localparam int LARGE_ENTRIES = 256;
   localparam int LARGE_AW      = $clog2(LARGE_ENTRIES);

   localparam logic [31:0] LARGE_FLAG = 32'h8000_0000;
   localparam logic [31:0] LARGE_MASK = 32'h7fff_ffff;

   typedef enum logic [2:0] {
      KIND_LOAD_FANOUT = 3'd0,
      KIND_LOAD_ENTRY  = 3'd1,
      KIND_LOAD_LARGE  = 3'd2,
      KIND_LOOKUP      = 3'd3,
      KIND_QUERY       = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_MISSING   = 2'd1,
      STATUS_LARGE_BAD = 2'd2
   } status_type;

   typedef enum logic [9:0] {
      ST_CLEAR      = 10'b00_0000_0001,
      ST_IDLE       = 10'b00_0000_0010,
      ST_FAN_LO     = 10'b00_0000_0100,
      ST_FAN_HI     = 10'b00_0000_1000,
      ST_FAN_DONE   = 10'b00_0001_0000,
      ST_SEARCH     = 10'b00_0010_0000,
      ST_COMPARE    = 10'b00_0100_0000,
      ST_OBJ_RD     = 10'b00_1000_0000,
      ST_OBJ_WAIT   = 10'b01_0000_0000,
      ST_FINISH     = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic load_wr;
      logic capture;
      logic fan_rd;
      logic fan_sel_hi;
      logic set_lo;
      logic set_hi;
      logic key_rd;
      logic lo_up;
      logic hi_down;
      logic obj_rd;
      logic large_rd;
      logic set_missing;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic range_ok;
      logic key_eq;
      logic key_lt;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

// ----- hdl/pil_ctrl.sv -----
// Controller FSM sequencing clearing, loads, fanout reads, the binary search and object reads.
`default_nettype none
module pil_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [2:0]        req_kind,
   output logic                   req_ready,
   input  pil_pkg::stat_type      stat,
   output pil_pkg::cmd_type       cmd
);

   pil_pkg::state_type state_ff, state_in;
   logic accept;

   assign req_ready = (state_ff == pil_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         pil_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_done) begin
               state_in = pil_pkg::ST_IDLE;
            end
         end
         pil_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               case (req_kind)
                  pil_pkg::KIND_LOAD_FANOUT,
                  pil_pkg::KIND_LOAD_ENTRY,
                  pil_pkg::KIND_LOAD_LARGE: cmd.load_wr = 1'b1;
                  pil_pkg::KIND_LOOKUP:     state_in = pil_pkg::ST_FAN_LO;
                  pil_pkg::KIND_QUERY:      state_in = pil_pkg::ST_OBJ_RD;
                  default:                  state_in = pil_pkg::ST_IDLE;
               endcase
            end
         end
         pil_pkg::ST_FAN_LO: begin
            cmd.fan_rd = 1'b1;
            state_in   = pil_pkg::ST_FAN_HI;
         end
         pil_pkg::ST_FAN_HI: begin
            cmd.fan_rd     = 1'b1;
            cmd.fan_sel_hi = 1'b1;
            cmd.set_lo     = 1'b1;
            state_in       = pil_pkg::ST_FAN_DONE;
         end
         pil_pkg::ST_FAN_DONE: begin
            cmd.set_hi = 1'b1;
            state_in   = pil_pkg::ST_SEARCH;
         end
         pil_pkg::ST_SEARCH: begin
            if (stat.range_ok) begin
               cmd.key_rd = 1'b1;
               state_in   = pil_pkg::ST_COMPARE;
            end else begin
               cmd.set_missing = 1'b1;
               state_in        = pil_pkg::ST_FINISH;
            end
         end
         pil_pkg::ST_COMPARE: begin
            if (stat.key_eq) begin
               state_in = pil_pkg::ST_OBJ_RD;
            end else if (stat.key_lt) begin
               cmd.lo_up = 1'b1;
               state_in  = pil_pkg::ST_SEARCH;
            end else begin
               cmd.hi_down = 1'b1;
               state_in    = pil_pkg::ST_SEARCH;
            end
         end
         pil_pkg::ST_OBJ_RD: begin
            cmd.obj_rd = 1'b1;
            state_in   = pil_pkg::ST_OBJ_WAIT;
         end
         pil_pkg::ST_OBJ_WAIT: begin
            cmd.large_rd = 1'b1;
            state_in     = pil_pkg::ST_FINISH;
         end
         pil_pkg::ST_FINISH: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = pil_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pil_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pil_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.out_free)
      else $error("response loaded while output register is occupied");
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.key_rd |-> stat.range_ok)
      else $error("key probe issued on an empty search range");
   a_no_accept_clear: assert property (@(posedge clock)
      (state_ff == pil_pkg::ST_CLEAR) |-> !req_ready)
      else $error("transaction accepted during clearing pass");
   a_compare_follows_probe: assert property (@(posedge clock) disable iff (reset)
      cmd.key_rd |=> (state_ff == pil_pkg::ST_COMPARE))
      else $error("key probe not followed by compare");
`endif

endmodule
`default_nettype wire

// ----- hdl/pil_datapath.sv -----
// Datapath with the index memories, search bounds, key compare and response register.
`default_nettype none
module pil_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  pil_pkg::cmd_type            cmd,
   output pil_pkg::stat_type           stat,
   input  wire logic [2:0]             req_kind,
   input  wire logic [11:0]            req_slot,
   input  wire logic [63:0]            req_key_high,
   input  wire logic [63:0]            req_key_middle,
   input  wire logic [31:0]            req_key_low,
   input  wire logic [31:0]            req_entry_crc,
   input  wire logic [63:0]            req_load_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [11:0]                 rsp_position,
   output logic [63:0]                 rsp_object_offset,
   output logic [31:0]                 rsp_object_crc
);

   localparam int AW = pil_pkg::OBJ_AW;
   localparam int CW = pil_pkg::CNT_W;
   localparam int FW = pil_pkg::FAN_AW;
   localparam int LW = pil_pkg::LARGE_AW;

   logic [CW-1:0] fan_mem [pil_pkg::FAN_ENTRIES];
   logic [63:0]   keyh_mem [pil_pkg::MAX_OBJECTS];
   logic [63:0]   keym_mem [pil_pkg::MAX_OBJECTS];
   logic [31:0]   keyl_mem [pil_pkg::MAX_OBJECTS];
   logic [31:0]   crc_mem [pil_pkg::MAX_OBJECTS];
   logic [31:0]   off_mem [pil_pkg::MAX_OBJECTS];
   logic [63:0]   large_mem [pil_pkg::LARGE_ENTRIES];

   logic [CW-1:0] fan_q_ff;
   logic [63:0]   keyh_q_ff, keym_q_ff, large_q_ff;
   logic [31:0]   keyl_q_ff, crc_q_ff, off_q_ff;

   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [63:0]   khi_ff, kmid_ff;
   logic [31:0]   klo_ff;
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic          missing_ff, missing_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [11:0]   rsp_position_ff, rsp_position_in;
   logic [63:0]   rsp_offset_ff, rsp_offset_in;
   logic [31:0]   rsp_crc_ff, rsp_crc_in;

   logic [FW-1:0] first;
   logic [FW-1:0] fan_addr;
   logic [CW-1:0] fan_clamped;
   logic [CW-1:0] mid;
   logic          wr_fan, wr_obj, wr_large;
   logic [FW-1:0] fan_waddr;
   logic [CW-1:0] fan_wdata;
   logic [AW-1:0] obj_waddr;
   logic [63:0]   keyh_wdata, keym_wdata, large_wdata;
   logic [31:0]   keyl_wdata, crc_wdata, off_wdata;
   logic [LW-1:0] large_waddr;
   logic          large_flag, large_bad;

   assign first       = khi_ff[63 -: FW];
   assign fan_addr    = cmd.fan_sel_hi ? first : first - FW'(1);
   assign fan_clamped = (fan_q_ff > CW'(pil_pkg::MAX_OBJECTS)) ?
                        CW'(pil_pkg::MAX_OBJECTS) : fan_q_ff;
   assign mid         = lo_ff + ((hi_ff - lo_ff) >> 1);

   // During the clearing pass every store is written with zeros, one row a cycle.
   always_comb begin
      wr_fan      = cmd.clear_wr;
      wr_obj      = cmd.clear_wr;
      wr_large    = cmd.clear_wr;
      fan_waddr   = clr_cnt_ff[FW-1:0];
      obj_waddr   = clr_cnt_ff;
      large_waddr = clr_cnt_ff[LW-1:0];
      fan_wdata   = '0;
      keyh_wdata  = '0;
      keym_wdata  = '0;
      keyl_wdata  = '0;
      crc_wdata   = '0;
      off_wdata   = '0;
      large_wdata = '0;
      if (cmd.load_wr) begin
         wr_fan      = (req_kind == pil_pkg::KIND_LOAD_FANOUT) &&
                       (req_slot < 12'(pil_pkg::FAN_ENTRIES));
         wr_obj      = (req_kind == pil_pkg::KIND_LOAD_ENTRY);
         wr_large    = (req_kind == pil_pkg::KIND_LOAD_LARGE) &&
                       (req_slot < 12'(pil_pkg::LARGE_ENTRIES));
         fan_waddr   = req_slot[FW-1:0];
         obj_waddr   = req_slot[AW-1:0];
         large_waddr = req_slot[LW-1:0];
         fan_wdata   = req_load_value[CW-1:0];
         keyh_wdata  = req_key_high;
         keym_wdata  = req_key_middle;
         keyl_wdata  = req_key_low;
         crc_wdata   = req_entry_crc;
         off_wdata   = req_load_value[31:0];
         large_wdata = req_load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fan) begin
         fan_mem[fan_waddr] <= fan_wdata;
      end
      if (cmd.fan_rd) begin
         fan_q_ff <= fan_mem[fan_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_obj) begin
         keyh_mem[obj_waddr] <= keyh_wdata;
      end
      if (cmd.key_rd) begin
         keyh_q_ff <= keyh_mem[mid[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_obj) begin
         keym_mem[obj_waddr] <= keym_wdata;
      end
      if (cmd.key_rd) begin
         keym_q_ff <= keym_mem[mid[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_obj) begin
         keyl_mem[obj_waddr] <= keyl_wdata;
      end
      if (cmd.key_rd) begin
         keyl_q_ff <= keyl_mem[mid[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_obj) begin
         crc_mem[obj_waddr] <= crc_wdata;
      end
      if (cmd.obj_rd) begin
         crc_q_ff <= crc_mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_obj) begin
         off_mem[obj_waddr] <= off_wdata;
      end
      if (cmd.obj_rd) begin
         off_q_ff <= off_mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_large) begin
         large_mem[large_waddr] <= large_wdata;
      end
      if (cmd.large_rd) begin
         large_q_ff <= large_mem[off_q_ff[LW-1:0]];
      end
   end

   assign clr_cnt_in = cmd.clear_wr ? clr_cnt_ff + AW'(1) : clr_cnt_ff;

   always_comb begin
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      pos_in     = pos_ff;
      missing_in = missing_ff;
      if (cmd.capture) begin
         pos_in     = req_slot[AW-1:0];
         missing_in = 1'b0;
      end
      if (cmd.set_lo) begin
         lo_in = (first == '0) ? '0 : fan_clamped;
      end
      if (cmd.set_hi) begin
         hi_in = fan_clamped;
      end
      if (cmd.key_rd) begin
         pos_in = mid[AW-1:0];
      end
      if (cmd.lo_up) begin
         lo_in = {1'b0, pos_ff} + CW'(1);
      end
      if (cmd.hi_down) begin
         hi_in = {1'b0, pos_ff};
      end
      if (cmd.set_missing) begin
         missing_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         khi_ff  <= req_key_high;
         kmid_ff <= req_key_middle;
         klo_ff  <= req_key_low;
      end
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      pos_ff     <= pos_in;
      missing_ff <= missing_in;
   end

   // An offset word with the flag set names a large-table row by its low 31 bits.
   assign large_flag = (off_q_ff & pil_pkg::LARGE_FLAG) != '0;
   assign large_bad  = large_flag &&
                       (((off_q_ff & pil_pkg::LARGE_MASK) >> LW) != '0);

   always_comb begin
      rsp_status_in   = pil_pkg::STATUS_FOUND;
      rsp_position_in = 12'(pos_ff);
      rsp_offset_in   = {32'd0, off_q_ff};
      rsp_crc_in      = crc_q_ff;
      if (missing_ff) begin
         rsp_status_in   = pil_pkg::STATUS_MISSING;
         rsp_position_in = '0;
         rsp_offset_in   = '0;
         rsp_crc_in      = '0;
      end else if (large_bad) begin
         rsp_status_in = pil_pkg::STATUS_LARGE_BAD;
         rsp_offset_in = '0;
      end else if (large_flag) begin
         rsp_offset_in = large_q_ff;
      end
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clr_cnt_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         clr_cnt_ff   <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_position_ff <= rsp_position_in;
         rsp_offset_ff   <= rsp_offset_in;
         rsp_crc_ff      <= rsp_crc_in;
      end
   end

   assign stat.clear_done = (clr_cnt_ff == '1);
   assign stat.range_ok   = lo_ff < hi_ff;
   assign stat.key_eq     = {keyh_q_ff, keym_q_ff, keyl_q_ff} == {khi_ff, kmid_ff, klo_ff};
   assign stat.key_lt     = {keyh_q_ff, keym_q_ff, keyl_q_ff} < {khi_ff, kmid_ff, klo_ff};
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_object_offset = rsp_offset_ff;
   assign rsp_object_crc    = rsp_crc_ff;

endmodule
`default_nettype wire

// ----- hdl/pack_index_lookup_unit.sv -----
// Top level of the pack index lookup unit: controller and datapath.
// A load is written in the cycle it is accepted. A position query reads the offset and CRC
// entries and then the large table. A lookup reads the two fanout bounds, then runs up to 13
// probes (a synchronous key memory read, then a compare), then the offset, CRC and large reads.
// One transaction is processed at a time; a finished response waits in an output register.
// After reset a clearing pass zeros every row of all stores; no request is taken meanwhile.
`default_nettype none
module pack_index_lookup_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_kind,
   input  wire logic [11:0] req_slot,
   input  wire logic [63:0] req_key_high,
   input  wire logic [63:0] req_key_middle,
   input  wire logic [31:0] req_key_low,
   input  wire logic [31:0] req_entry_crc,
   input  wire logic [63:0] req_load_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [11:0]      rsp_position,
   output logic [63:0]      rsp_object_offset,
   output logic [31:0]      rsp_object_crc
);

   pil_pkg::cmd_type  cmd;
   pil_pkg::stat_type stat;

   pil_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pil_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_kind),
      .req_slot          (req_slot),
      .req_key_high      (req_key_high),
      .req_key_middle    (req_key_middle),
      .req_key_low       (req_key_low),
      .req_entry_crc     (req_entry_crc),
      .req_load_value    (req_load_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_position      (rsp_position),
      .rsp_object_offset (rsp_object_offset),
      .rsp_object_crc    (rsp_object_crc)
   );

endmodule
`default_nettype wire
